FILE: hw/rtl/dra_pkg.sv
// Shared types and constants of the descriptor ring block allocator.
// No dependencies; every other file of the block imports this package.
package dra_pkg;

   localparam int unsigned DESCRIPTORS_DEFAULT = 16;
   localparam int unsigned FIELD_W = 17;
   localparam logic [FIELD_W-1:0] DATA_BYTES = 17'h10000;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_TOO_LARGE = 3'd1,
      STATUS_RING_FULL = 3'd2,
      STATUS_OVERLAP   = 3'd3,
      STATUS_EMPTY     = 3'd4
   } status_type;

   typedef enum logic {
      CMD_PUSH = 1'b0,
      CMD_POP  = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type            cmd;
      logic [FIELD_W-1:0] block_length;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [FIELD_W-1:0] offset;
      logic [FIELD_W-1:0] length;
      logic               last;
   } rsp_type;

   // One descriptor as it moves along the ring of cells.
   typedef struct packed {
      logic               valid;
      logic [FIELD_W-1:0] offset;
      logic [FIELD_W-1:0] length;
   } entry_type;

   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctrl_type;

endpackage

FILE: hw/rtl/descriptor_ring_block_allocator.sv
// Top level of the descriptor ring block allocator: control, write offset,
// area size register and the ring of dra_cell instances. Uses dra_pkg, dra_cell.
//
// The allocator hands out blocks of a circular data area and keeps one
// descriptor per pending block in a ring of DESCRIPTORS cells, oldest block
// in cell 0. A request is taken when start is high and busy is low. A push
// that is too large or finds the ring full answers on the cycle after it is
// taken and leaves busy low. Any other push first wraps the write offset if
// needed, then rotates the whole ring once past a single overlap comparator
// with busy high throughout, and the response appears in the first cycle in
// which busy is low again. A pop with n pending blocks streams n responses,
// one per cycle as cell 0 is drained and the ring shifts, with last set on
// the final one; busy stays high while they stream. A pop of an empty ring
// answers once with status empty on the next cycle. Every response is valid
// on rsp_payload for exactly one cycle, marked by rsp_valid, and cannot be
// held off by the receiver. The area size register may be written on any
// cycle the block is idle; values above the built size are saturated to it.
// No clearing pass is needed after reset.
module descriptor_ring_block_allocator #(
   parameter int unsigned DESCRIPTORS = dra_pkg::DESCRIPTORS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  dra_pkg::req_type              req_payload,
   output logic                          rsp_valid,
   output dra_pkg::rsp_type              rsp_payload,
   input  logic                          csr_write_enable,
   input  logic [dra_pkg::FIELD_W-1:0]   csr_write_data
);
   import dra_pkg::*;

   localparam int unsigned IDX_W = $clog2(DESCRIPTORS);
   localparam int unsigned CNT_W = $clog2(DESCRIPTORS + 1);
   localparam logic [IDX_W-1:0] SCAN_END = IDX_W'(DESCRIPTORS - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DESCRIPTORS);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_WRAP   = 5'b00010,
      ST_SCAN   = 5'b00100,
      ST_FINISH = 5'b01000,
      ST_POP    = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   logic [FIELD_W-1:0] size_ff, size_in;
   logic [FIELD_W-1:0] write_offset_ff, write_offset_in;
   logic [FIELD_W-1:0] length_ff, length_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   scan_ff, scan_in;
   logic               overlap_ff, overlap_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   entry_type     cells [DESCRIPTORS];
   entry_type     tail_entry;
   entry_type     new_entry;
   logic          ring_shift;
   logic          ring_load;
   logic          accept;
   logic          head_hit;
   logic [FIELD_W-1:0] head_gap;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   // During a scan the ring rotates, so the head returns to the tail and a
   // full revolution restores the order. During a pop the tail fills with
   // empty cells.
   always_comb begin
      tail_entry = cells[0];
      if (state_ff == ST_POP) begin
         tail_entry.valid = 1'b0;
      end
   end

   assign new_entry.valid  = 1'b1;
   assign new_entry.offset = write_offset_ff;
   assign new_entry.length = length_ff;

   // The pending block in cell 0 is hit when it starts inside the new block.
   assign head_gap = cells[0].offset - write_offset_ff;
   assign head_hit = cells[0].valid && (cells[0].offset >= write_offset_ff) &&
                     (head_gap < length_ff);

   always_comb begin
      state_in        = state_ff;
      size_in         = size_ff;
      write_offset_in = write_offset_ff;
      length_in       = length_ff;
      count_in        = count_ff;
      scan_in         = scan_ff;
      overlap_in      = overlap_ff;
      rsp_valid_in    = 1'b0;
      rsp_in          = rsp_ff;
      ring_shift      = 1'b0;
      ring_load       = 1'b0;

      if (csr_write_enable) begin
         size_in = (csr_write_data > DATA_BYTES) ? DATA_BYTES : csr_write_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               length_in = req_payload.block_length;
               rsp_in.offset = '0;
               rsp_in.length = req_payload.block_length;
               rsp_in.last   = 1'b1;
               if (req_payload.cmd == CMD_POP) begin
                  if (count_ff == '0) begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = STATUS_EMPTY;
                     rsp_in.length = '0;
                  end else begin
                     state_in = ST_POP;
                  end
               end else if (req_payload.block_length > size_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_in.status = STATUS_TOO_LARGE;
               end else if (count_ff == CNT_FULL) begin
                  rsp_valid_in  = 1'b1;
                  rsp_in.status = STATUS_RING_FULL;
               end else begin
                  state_in = ST_WRAP;
               end
            end
         end
         ST_WRAP: begin
            // The wrap holds even if the push is later refused for overlap.
            if ((write_offset_ff > size_ff) ||
                (length_ff > (size_ff - write_offset_ff))) begin
               write_offset_in = '0;
            end
            scan_in    = '0;
            overlap_in = 1'b0;
            state_in   = ST_SCAN;
         end
         ST_SCAN: begin
            ring_shift = 1'b1;
            overlap_in = overlap_ff || head_hit;
            scan_in    = scan_ff + 1'b1;
            if (scan_ff == SCAN_END) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            rsp_valid_in  = 1'b1;
            rsp_in.length = length_ff;
            rsp_in.last   = 1'b1;
            if (overlap_ff) begin
               rsp_in.status = STATUS_OVERLAP;
               rsp_in.offset = '0;
            end else begin
               ring_load       = 1'b1;
               count_in        = count_ff + 1'b1;
               rsp_in.status   = STATUS_OK;
               rsp_in.offset   = write_offset_ff;
               write_offset_in = write_offset_ff + length_ff;
            end
            state_in = ST_IDLE;
         end
         ST_POP: begin
            // Pending blocks sit in cells 0 to count - 1, so cell 0 is valid
            // here and the next cell tells whether this one is the last.
            ring_shift    = 1'b1;
            rsp_valid_in  = 1'b1;
            rsp_in.status = STATUS_OK;
            rsp_in.offset = cells[0].offset;
            rsp_in.length = cells[0].length;
            rsp_in.last   = !cells[1].valid;
            if (!cells[1].valid) begin
               count_in = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         size_ff         <= DATA_BYTES;
         write_offset_ff <= '0;
         count_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         size_ff         <= size_in;
         write_offset_ff <= write_offset_in;
         count_ff        <= count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      length_ff  <= length_in;
      scan_ff    <= scan_in;
      overlap_ff <= overlap_in;
      rsp_ff     <= rsp_in;
   end

   // The ring: each cell takes its neighbor's entry on a shift, and the
   // cell just past the last pending block takes the new descriptor.
   for (genvar i = 0; i < DESCRIPTORS; i++) begin : g_cell
      cell_ctrl_type ctrl;
      entry_type     shift_entry;

      assign ctrl.shift = ring_shift;
      assign ctrl.load  = ring_load && (count_ff == CNT_W'(i));

      if (i == DESCRIPTORS - 1) begin : g_tail
         assign shift_entry = tail_entry;
      end else begin : g_body
         assign shift_entry = cells[i+1];
      end

      dra_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .shift_entry (shift_entry),
         .load_entry  (new_entry),
         .entry       (cells[i])
      );
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

FILE: hw/rtl/dra_cell.sv
// One descriptor cell of the allocator ring.
// Depends on dra_pkg for the entry and control types.
module dra_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  dra_pkg::cell_ctrl_type ctrl,
   input  dra_pkg::entry_type    shift_entry,
   input  dra_pkg::entry_type    load_entry,
   output dra_pkg::entry_type    entry
);
   import dra_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.load) begin
         entry_in = load_entry;
      end else if (ctrl.shift) begin
         entry_in = shift_entry;
      end
   end

   // Only the valid bit needs a reset; the payload is read while valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
      entry_ff.offset <= entry_in.offset;
      entry_ff.length <= entry_in.length;
   end

   assign entry = entry_ff;

endmodule

FILE: hw/rtl/dra_checker.sv
// Port-level checks for the descriptor ring block allocator, bound to it.
// Depends on dra_pkg and on descriptor_ring_block_allocator.
module dra_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic                        rsp_valid,
   input dra_pkg::rsp_type            rsp_payload
);
   import dra_pkg::*;

   // A taken request either answers at once or keeps the block busy.
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> rsp_valid || busy)
      else $error("accepted request neither answered nor kept busy");

   // While more pop responses are due the block takes no new request.
   a_more_means_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.last |-> busy)
      else $error("unfinished response stream while idle");

   // A refusal or an empty pop is always a single response.
   a_refusal_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status != STATUS_OK) |-> rsp_payload.last)
      else $error("refusal without last");

   // An empty pop reports no block.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status == STATUS_EMPTY) |->
      (rsp_payload.offset == '0) && (rsp_payload.length == '0))
      else $error("empty response carries a block");

endmodule

bind descriptor_ring_block_allocator dra_checker u_dra_checker (.*);
